// ----- src/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned PHASE_W = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BCNT_W  = 4;
  localparam int unsigned CMD_W   = 3;

  localparam logic [BCNT_W-1:0] BITS_PER_BYTE = BCNT_W'(BYTE_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic {
    REG_PHASE_TICKS = 1'b0,
    REG_UNMAPPED    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] write_byte;
    logic              send_nack;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    cmd_e               active;
    logic [BCNT_W-1:0]  bit_count;
    logic               half_phase;
    logic [PHASE_W-1:0] tick_count;
    logic [BYTE_W-1:0]  shift;
    logic               scl;
    logic               sda;
    logic               release_sda;
    logic               ack;
    logic               nack_hold;
    logic [BYTE_W-1:0]  read_hold;
  } eng_state_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_released;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              ack_received;
  } result_t;

endpackage

// ----- src/i2cm_cfg.sv -----
// APB-style register file holding the phase length.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_cfg
  import i2cm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [PHASE_W-1:0] phase_ticks_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  reg_idx_e           idx;

  assign idx    = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_comb begin
    phase_d = phase_q;
    if (psel && penable && pwrite && pready && idx == REG_PHASE_TICKS) begin
      phase_d = pwdata[PHASE_W-1:0];
    end
  end

  always_comb begin
    unique case (idx)
      REG_PHASE_TICKS: prdata = {{(32-PHASE_W){1'b0}}, phase_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_W'(1);
    end else begin
      phase_q <= phase_d;
    end
  end

  assign phase_ticks_o = phase_q;

endmodule

// ----- src/i2cm_step.sv -----
// Per-tick next-state and result logic of the line sequencer.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_step
  import i2cm_pkg::*;
(
  input  eng_state_t         state_i,
  input  item_t              item_i,
  input  logic [PHASE_W-1:0] phase_ticks_i,
  output eng_state_t         state_o,
  output result_t            result_o
);

  logic [PHASE_W-1:0] plen;
  logic [PHASE_W:0]   tick_inc;
  logic [BCNT_W-1:0]  bc_inc;
  logic [BYTE_W-1:0]  shift_up;
  logic               done;
  eng_state_t         s;

  assign plen     = (phase_ticks_i == '0) ? PHASE_W'(1) : phase_ticks_i;
  assign tick_inc = {1'b0, state_i.tick_count} + (PHASE_W+1)'(1);
  assign bc_inc   = state_i.bit_count + BCNT_W'(1);
  assign shift_up = {state_i.shift[BYTE_W-2:0], 1'b0};

  always_comb begin
    s    = state_i;
    done = 1'b0;
    if (state_i.active == CMD_NONE) begin
      unique case (cmd_e'(item_i.command))
        CMD_START: begin
          s.active = CMD_START;
          s.sda    = 1'b1;
          s.scl    = 1'b1;
        end
        CMD_STOP: begin
          s.active = CMD_STOP;
          s.sda    = 1'b0;
          s.scl    = 1'b0;
        end
        CMD_WRITE: begin
          s.active = CMD_WRITE;
          s.shift  = item_i.write_byte;
          s.sda    = item_i.write_byte[BYTE_W-1];
          s.scl    = 1'b0;
        end
        CMD_READ: begin
          s.active    = CMD_READ;
          s.nack_hold = item_i.send_nack;
          s.shift     = '0;
          s.sda       = 1'b1;
          s.scl       = 1'b0;
        end
        default: ;
      endcase
      if (s.active != CMD_NONE) begin
        s.bit_count   = '0;
        s.half_phase  = 1'b0;
        s.tick_count  = '0;
        s.release_sda = (s.active == CMD_READ);
      end
    end else if (tick_inc < {1'b0, plen}) begin
      s.tick_count = tick_inc[PHASE_W-1:0];
    end else begin
      s.tick_count = '0;
      if (!state_i.half_phase) begin
        s.half_phase = 1'b1;
        if (state_i.active == CMD_START) begin
          s.sda = 1'b0;
        end else begin
          s.scl = 1'b1;
          if (state_i.active == CMD_WRITE && state_i.bit_count == BITS_PER_BYTE) begin
            s.ack = item_i.sda_in;
          end
          if (state_i.active == CMD_READ && state_i.bit_count < BITS_PER_BYTE) begin
            s.shift = {state_i.shift[BYTE_W-2:0], item_i.sda_in};
          end
        end
      end else if (state_i.active == CMD_START) begin
        s.scl = 1'b0;
        done  = 1'b1;
      end else if (state_i.active == CMD_STOP) begin
        s.sda = 1'b1;
        done  = 1'b1;
      end else if (state_i.bit_count >= BITS_PER_BYTE) begin
        s.scl         = 1'b0;
        s.release_sda = 1'b0;
        done          = 1'b1;
        if (state_i.active == CMD_WRITE) begin
          s.sda = 1'b1;
        end else begin
          s.read_hold = state_i.shift;
        end
      end else begin
        s.scl        = 1'b0;
        s.half_phase = 1'b0;
        s.bit_count  = bc_inc;
        if (state_i.active == CMD_WRITE) begin
          s.shift = shift_up;
          if (bc_inc == BITS_PER_BYTE) begin
            s.release_sda = 1'b1;
            s.sda         = 1'b1;
          end else begin
            s.sda = shift_up[BYTE_W-1];
          end
        end else if (bc_inc == BITS_PER_BYTE) begin
          s.release_sda = 1'b0;
          s.sda         = state_i.nack_hold;
        end
      end
      if (done) begin
        s.active     = CMD_NONE;
        s.bit_count  = '0;
        s.half_phase = 1'b0;
      end
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.scl_level    = s.scl;
    result_o.sda_level    = s.release_sda | s.sda;
    result_o.sda_released = s.release_sda;
    result_o.busy_res     = (s.active != CMD_NONE);
    result_o.done_res     = done;
    result_o.read_byte    = s.read_hold;
    result_o.ack_received = s.ack;
  end

endmodule

// ----- src/i2c_master_byte_engine_core.sv -----
// I2C master byte engine: one tick beat in, one line-level result beat out.
// Tick beats are held in an item register, results in a result register.
// Throughput: one beat per cycle when not stalled; the sequencer state
// updates once per beat. Reset: engine idle, lines low, phase_ticks = 1.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_step.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core
  import i2cm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [BYTE_W-1:0] write_byte_i,
  input  logic              send_nack_i,
  input  logic              sda_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              scl_level_o,
  output logic              sda_level_o,
  output logic              sda_released_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              ack_received_o
);

  logic [PHASE_W-1:0] phase_ticks;
  logic               in_vld_q, in_vld_d;
  item_t              item_q;
  logic               out_vld_q, out_vld_d;
  result_t            res_q, res_d;
  eng_state_t         st_q, st_d;
  logic               out_free, advance, accept;

  i2cm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .phase_ticks_o (phase_ticks)
  );

  i2cm_step u_step (
    .state_i       (st_q),
    .item_i        (item_q),
    .phase_ticks_i (phase_ticks),
    .state_o       (st_d),
    .result_o      (res_d)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{active: CMD_NONE, default: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{command: command_i, write_byte: write_byte_i,
                  send_nack: send_nack_i, sda_in: sda_in_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign scl_level_o    = res_q.scl_level;
  assign sda_level_o    = res_q.sda_level;
  assign sda_released_o = res_q.sda_released;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign read_byte_o    = res_q.read_byte;
  assign ack_received_o = res_q.ack_received;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done and busy in the same result beat");

  a_released_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.sda_released |-> res_q.sda_level)
    else $error("released SDA reported low");

  a_idle_counters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.active == CMD_NONE |-> (st_q.bit_count == '0 && !st_q.half_phase))
    else $error("idle engine with live bit or phase counter");

  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("engine state moved without a beat");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for i2c_master_byte_engine_core: sends tick beats, predicts the
// line levels of every result beat and compares them field by field.
// Depends on i2cm_pkg and the engine RTL; reads and writes no files.
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  localparam int unsigned STUCK_LIMIT = 20000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [2:0]        paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i      = '0;
  logic [BYTE_W-1:0] write_byte_i   = '0;
  logic              send_nack_i    = 1'b0;
  logic              sda_in_i       = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              scl_level_o;
  logic              sda_level_o;
  logic              sda_released_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic [BYTE_W-1:0] read_byte_o;
  logic              ack_received_o;

  // line engine predictor
  cmd_e               eng_cmd       = CMD_NONE;
  logic [BCNT_W-1:0]  eng_bits      = '0;
  logic               eng_high_half = 1'b0;
  logic [PHASE_W-1:0] eng_ticks     = '0;
  logic [PHASE_W-1:0] phase_ticks_q = 10'd1;
  logic [BYTE_W-1:0]  eng_shift     = '0;
  logic [BYTE_W-1:0]  eng_read      = '0;
  logic               eng_scl       = 1'b0;
  logic               eng_sda       = 1'b0;
  logic               eng_rel       = 1'b0;
  logic               eng_ack       = 1'b0;
  logic               eng_nack      = 1'b0;

  result_t expected_levels[$];
  result_t want_levels;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;
  int mismatches   = 0;
  int tick_beats   = 0;
  int level_beats  = 0;
  int commands_run = 0;
  int cfg_writes   = 0;

  i2c_master_byte_engine_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .write_byte_i   (write_byte_i),
    .send_nack_i    (send_nack_i),
    .sda_in_i       (sda_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_level_o    (scl_level_o),
    .sda_level_o    (sda_level_o),
    .sda_released_o (sda_released_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_byte_o    (read_byte_o),
    .ack_received_o (ack_received_o)
  );

  always #4 clk_i = ~clk_i;

  // close the current half bit; return 1 when the command completes
  function automatic logic close_phase(logic sda_now);
    if (!eng_high_half) begin
      eng_high_half = 1'b1;
      if (eng_cmd == CMD_START) begin
        eng_sda = 1'b0;
      end else begin
        eng_scl = 1'b1;
        if (eng_cmd == CMD_WRITE && eng_bits == BITS_PER_BYTE) eng_ack = sda_now;
        if (eng_cmd == CMD_READ && eng_bits < BITS_PER_BYTE) begin
          eng_shift = {eng_shift[BYTE_W-2:0], sda_now};
        end
      end
      return 1'b0;
    end
    if (eng_cmd == CMD_START) begin
      eng_scl = 1'b0;
      return 1'b1;
    end
    if (eng_cmd == CMD_STOP) begin
      eng_sda = 1'b1;
      return 1'b1;
    end
    eng_scl = 1'b0;
    if (eng_bits >= BITS_PER_BYTE) begin
      eng_rel = 1'b0;
      if (eng_cmd == CMD_WRITE) eng_sda = 1'b1;
      else eng_read = eng_shift;
      return 1'b1;
    end
    eng_high_half = 1'b0;
    eng_bits = eng_bits + BCNT_W'(1);
    if (eng_cmd == CMD_WRITE) begin
      eng_shift = eng_shift << 1;
      if (eng_bits == BITS_PER_BYTE) begin
        eng_rel = 1'b1;
        eng_sda = 1'b1;
      end else begin
        eng_sda = eng_shift[BYTE_W-1];
      end
    end else if (eng_bits == BITS_PER_BYTE) begin
      eng_rel = 1'b0;
      eng_sda = eng_nack;
    end
    return 1'b0;
  endfunction

  function automatic void predict_levels(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte,
                                         logic nack, logic sda_now);
    result_t            r;
    logic               done;
    logic [PHASE_W-1:0] plen;
    done = 1'b0;
    plen = (phase_ticks_q == '0) ? 10'd1 : phase_ticks_q;
    if (eng_cmd == CMD_NONE) begin
      if (cmd >= CMD_START && cmd <= CMD_READ) begin
        eng_cmd       = cmd_e'(cmd);
        eng_bits      = '0;
        eng_high_half = 1'b0;
        eng_ticks     = '0;
        eng_rel       = 1'b0;
        case (eng_cmd)
          CMD_START: begin
            eng_sda = 1'b1;
            eng_scl = 1'b1;
          end
          CMD_STOP: begin
            eng_sda = 1'b0;
            eng_scl = 1'b0;
          end
          CMD_WRITE: begin
            eng_shift = wbyte;
            eng_sda   = wbyte[BYTE_W-1];
            eng_scl   = 1'b0;
          end
          default: begin
            eng_nack  = nack;
            eng_shift = '0;
            eng_sda   = 1'b1;
            eng_rel   = 1'b1;
            eng_scl   = 1'b0;
          end
        endcase
      end
    end else begin
      eng_ticks = eng_ticks + PHASE_W'(1);
      if (eng_ticks >= plen) begin
        eng_ticks = '0;
        if (close_phase(sda_now)) begin
          eng_cmd       = CMD_NONE;
          eng_bits      = '0;
          eng_high_half = 1'b0;
          done          = 1'b1;
        end
      end
    end
    r.scl_level    = eng_scl;
    r.sda_level    = eng_rel ? 1'b1 : eng_sda;
    r.sda_released = eng_rel;
    r.busy_res     = (eng_cmd != CMD_NONE);
    r.done_res     = done;
    r.read_byte    = eng_read;
    r.ack_received = eng_ack;
    expected_levels.push_back(r);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      level_beats++;
      if (expected_levels.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want_levels = expected_levels.pop_front();
        check_field("scl_level", want_levels.scl_level, scl_level_o);
        check_field("sda_level", want_levels.sda_level, sda_level_o);
        check_field("sda_released", want_levels.sda_released, sda_released_o);
        check_field("busy_res", want_levels.busy_res, busy_res_o);
        check_field("done_res", want_levels.done_res, done_res_o);
        check_field("read_byte", want_levels.read_byte, read_byte_o);
        check_field("ack_received", want_levels.ack_received, ack_received_o);
      end
    end
  end

  // receiver: long hold-off on request, else random stall
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i = 1'b1;
      rx_hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("tb: errors");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
                           input logic nack, input logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    command_i    = cmd;
    write_byte_i = wbyte;
    send_nack_i  = nack;
    sda_in_i     = sda;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tick_beats++;
    predict_levels(cmd, wbyte, nack, sda);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_levels.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_phase_ticks(input logic [PHASE_W-1:0] value);
    drain();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_PHASE_TICKS, 2'b00};
    pwdata  = {22'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    phase_ticks_q = value;
    cfg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // issue one command, then tick until the engine is idle again
  task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
                             input logic nack, input logic sda, input logic rand_sda,
                             input logic [CMD_W-1:0] busy_cmd);
    send_tick(cmd, wbyte, nack, rand_sda ? 1'($urandom) : sda);
    commands_run++;
    while (eng_cmd != CMD_NONE) begin
      send_tick(busy_cmd, 8'($urandom), 1'($urandom), rand_sda ? 1'($urandom) : sda);
    end
  endtask

  task automatic random_ticks(input int count);
    logic [CMD_W-1:0] cmd;
    int               roll;
    logic             in_frame;
    int               xfers_left;
    in_frame   = 1'b0;
    xfers_left = 0;
    repeat (count) begin
      if (eng_cmd != CMD_NONE) begin
        cmd = 3'($urandom_range(7));
      end else begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          cmd = 3'($urandom_range(7));
        end else if (roll < 15) begin
          cmd = CMD_NONE;
        end else if (!in_frame) begin
          cmd        = CMD_START;
          in_frame   = 1'b1;
          xfers_left = $urandom_range(1, 4);
        end else if (xfers_left == 0) begin
          cmd      = CMD_STOP;
          in_frame = 1'b0;
        end else begin
          cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
          xfers_left--;
        end
        if (cmd >= CMD_START && cmd <= CMD_READ) commands_run++;
      end
      send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    while (eng_cmd != CMD_NONE) send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_commands();
    send_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(3'd5, 8'hFF, 1'b1, 1'b1);
    send_tick(3'd6, 8'h00, 1'b0, 1'b0);
    send_tick(3'd7, 8'h5A, 1'b1, 1'b1);
    run_command(CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, CMD_WRITE);
    run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, CMD_NONE);
    run_command(CMD_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, CMD_READ);
    run_command(CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1, CMD_WRITE);
    run_command(CMD_WRITE, 8'h81, 1'b1, 1'b0, 1'b1, CMD_STOP);
    run_command(CMD_READ, 8'h00, 1'b1, 1'b1, 1'b0, CMD_READ);
    run_command(CMD_READ, 8'hFF, 1'b0, 1'b0, 1'b0, CMD_START);
    run_command(CMD_READ, 8'h3C, 1'b1, 1'b0, 1'b1, 3'd7);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b1, CMD_STOP);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b0, CMD_NONE);
    send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_phase_extremes();
    write_phase_ticks(10'd0);
    run_command(CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, CMD_NONE);
    run_command(CMD_WRITE, 8'h3C, 1'b0, 1'b0, 1'b1, CMD_NONE);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b1, CMD_NONE);
    write_phase_ticks(10'd64);
    run_command(CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, CMD_NONE);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b1, CMD_NONE);
    write_phase_ticks(10'd2);
    run_command(CMD_READ, 8'h00, 1'b1, 1'b0, 1'b1, CMD_NONE);
  endtask

  task automatic test_backpressure();
    write_phase_ticks(10'd1);
    rx_hold_left = 400;
    random_ticks(150);
    drain();
  endtask

  task automatic test_random_traffic(input logic [PHASE_W-1:0] phase, input int count);
    write_phase_ticks(phase);
    random_ticks(count);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 16;
    rx_idle_pct = 84;
    test_directed_commands();
    test_phase_extremes();
    test_random_traffic(10'($urandom_range(0, 4)), 80);
    test_random_traffic(10'd1, 80);

    tx_idle_pct = 84;
    rx_idle_pct = 16;
    test_backpressure();
    test_random_traffic(10'($urandom_range(0, 4)), 80);
    test_random_traffic(10'd3, 80);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(10'd0, 80);
    test_random_traffic(10'($urandom_range(1, 5)), 80);

    drain();
    repeat (10) @(posedge clk_i);
    if (expected_levels.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_levels.size());
      mismatches++;
    end
    $display("tb: %0d tick beats, %0d result beats, %0d commands, %0d phase_ticks writes",
             tick_beats, level_beats, commands_run, cfg_writes);
    $display("tb: phase lengths 0 to 64, idle mixes 16/84, 84/16 and none, long hold-off");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/i2cm_pkg.sv
src/i2cm_cfg.sv
src/i2cm_step.sv
src/i2c_master_byte_engine_core.sv
tb/sv/tb.sv
